// File: src/x86ea_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// x86ea_pkg: shared types and constants for the MOV effective-address decoder
// Opcode values, ModRM/SIB special encodings and the result record that
// travels from the parser to the output buffer.
// ----------------------------------------------------------------------------
package x86ea_pkg;

    localparam int unsigned REG_COUNT = 8;

    // Request kinds
    localparam logic REQ_REG_WRITE = 1'b0;
    localparam logic REQ_CODE_BYTE = 1'b1;

    // Supported opcodes
    localparam logic [7:0] OPC_MOV_RM_R   = 8'h89;
    localparam logic [7:0] OPC_MOV_R_RM   = 8'h8B;
    localparam logic [7:0] OPC_MOV_RM_IMM = 8'hC7;

    // ModRM / SIB encodings with special meaning
    localparam logic [1:0] MOD_NO_DISP  = 2'd0;
    localparam logic [1:0] MOD_DISP8    = 2'd1;
    localparam logic [1:0] MOD_DISP32   = 2'd2;
    localparam logic [1:0] MOD_REG      = 2'd3;
    localparam logic [2:0] RM_SIB       = 3'd4;
    localparam logic [2:0] RM_DISP_ONLY = 3'd5;
    localparam logic [2:0] SIB_NO_INDEX = 3'd4;
    localparam logic [2:0] SIB_NO_BASE  = 3'd5;

    // Result status codes
    localparam logic STATUS_OK         = 1'b0;
    localparam logic STATUS_BAD_OPCODE = 1'b1;

    typedef struct packed {
        logic        status;
        logic        writes_memory;
        logic        reads_memory;
        logic [2:0]  dest_reg;
        logic [31:0] mem_address;
        logic [31:0] data_value;
        logic [3:0]  instr_length;
    } ea_result_t;

endpackage
`default_nettype wire

// File: src/x86ea_parser.sv
`default_nettype none
// ----------------------------------------------------------------------------
// x86ea_parser: guest register file and byte-at-a-time MOV parser
// Updates parse state on every accepted code byte and, on the final byte of
// an instruction (or a bad opcode), produces the decoded result in the same
// cycle from the post-update parse state.
// ----------------------------------------------------------------------------
module x86ea_parser (
    input  wire logic                    aclk,
    input  wire logic                    aresetn,
    input  wire logic                    item_fire,
    input  wire logic                    req_type,
    input  wire logic [2:0]              reg_index,
    input  wire logic [31:0]             reg_value,
    input  wire logic [7:0]              code_byte,
    output logic                         emit,
    output x86ea_pkg::ea_result_t        result
);
    import x86ea_pkg::*;

    typedef enum logic [1:0] {
        PH_OPCODE,
        PH_MODRM,
        PH_SIB,
        PH_BODY
    } phase_t;

    phase_t      phase_reg, phase_next;
    logic [7:0]  opcode_reg, opcode_next;
    logic [7:0]  modrm_reg, modrm_next;
    logic [7:0]  sib_reg, sib_next;
    logic [31:0] disp_reg, disp_next;
    logic [31:0] imm_reg, imm_next;
    logic [3:0]  count_reg, count_next;
    logic [31:0] guest_reg [REG_COUNT];

    logic        byte_fire;
    logic        bad_opcode;
    logic        done;
    logic [3:0]  body_off;
    logic [2:0]  body_dl;
    logic [3:0]  imm_off;
    logic [1:0]  lane;
    logic [1:0]  f_mod;
    logic [2:0]  f_reg;
    logic [2:0]  f_rm;
    logic [2:0]  sib_base;
    logic [2:0]  sib_index;
    logic [1:0]  sib_scale;
    logic [2:0]  dl_final;
    logic [31:0] base_val;
    logic [31:0] index_val;
    logic [31:0] disp_val;
    logic [31:0] addr_val;

    function automatic logic sib_present(input logic [7:0] modrm);
        return (modrm[7:6] != MOD_REG) && (modrm[2:0] == RM_SIB);
    endfunction

    function automatic logic [2:0] disp_bytes(input logic [7:0] modrm, input logic [7:0] sib);
        logic [2:0] n;
        n = 3'd0;
        case (modrm[7:6])
            MOD_DISP8:  n = 3'd1;
            MOD_DISP32: n = 3'd4;
            MOD_NO_DISP: begin
                if (modrm[2:0] == RM_DISP_ONLY) begin
                    n = 3'd4;
                end else if (modrm[2:0] == RM_SIB && sib[2:0] == SIB_NO_BASE) begin
                    n = 3'd4;
                end
            end
            default: n = 3'd0;
        endcase
        return n;
    endfunction

    function automatic logic [3:0] total_bytes(input logic [7:0] opcode,
                                               input logic [7:0] modrm,
                                               input logic [7:0] sib);
        return 4'd2 + {3'd0, sib_present(modrm)} + {1'b0, disp_bytes(modrm, sib)}
               + ((opcode == OPC_MOV_RM_IMM) ? 4'd4 : 4'd0);
    endfunction

    assign byte_fire = item_fire && (req_type == REQ_CODE_BYTE);
    assign body_off  = count_reg - 4'd2 - {3'd0, sib_present(modrm_reg)};
    assign body_dl   = disp_bytes(modrm_reg, sib_reg);
    assign imm_off   = body_off - {1'b0, body_dl};
    assign lane      = (body_off < {1'b0, body_dl}) ? body_off[1:0] : imm_off[1:0];

    // Parse-state advance
    always_comb begin
        phase_next  = phase_reg;
        opcode_next = opcode_reg;
        modrm_next  = modrm_reg;
        sib_next    = sib_reg;
        disp_next   = disp_reg;
        imm_next    = imm_reg;
        count_next  = count_reg;
        bad_opcode  = 1'b0;
        if (byte_fire) begin
            case (phase_reg)
                PH_OPCODE: begin
                    if (code_byte inside {OPC_MOV_RM_R, OPC_MOV_R_RM, OPC_MOV_RM_IMM}) begin
                        opcode_next = code_byte;
                        count_next  = 4'd1;
                        phase_next  = PH_MODRM;
                    end else begin
                        bad_opcode = 1'b1;
                    end
                end
                PH_MODRM: begin
                    modrm_next = code_byte;
                    count_next = 4'd2;
                    phase_next = sib_present(code_byte) ? PH_SIB : PH_BODY;
                end
                PH_SIB: begin
                    sib_next   = code_byte;
                    count_next = 4'd3;
                    phase_next = PH_BODY;
                end
                PH_BODY: begin
                    if (body_off < {1'b0, body_dl}) begin
                        disp_next = disp_reg | ({24'd0, code_byte} << {lane, 3'b000});
                    end else begin
                        imm_next = imm_reg | ({24'd0, code_byte} << {lane, 3'b000});
                    end
                    count_next = count_reg + 4'd1;
                end
                default: phase_next = PH_OPCODE;
            endcase
        end
    end

    assign done = byte_fire && (phase_next == PH_BODY)
               && (count_next >= total_bytes(opcode_next, modrm_next, sib_next));
    assign emit = bad_opcode || done;

    // Effective address from the post-update ModRM/SIB/displacement
    assign f_mod     = modrm_next[7:6];
    assign f_reg     = modrm_next[5:3];
    assign f_rm      = modrm_next[2:0];
    assign sib_base  = sib_next[2:0];
    assign sib_index = sib_next[5:3];
    assign sib_scale = sib_next[7:6];
    assign dl_final  = disp_bytes(modrm_next, sib_next);

    always_comb begin
        base_val  = 32'd0;
        index_val = 32'd0;
        if (f_rm == RM_SIB) begin
            if (!(f_mod == MOD_NO_DISP && sib_base == SIB_NO_BASE)) begin
                base_val = guest_reg[sib_base];
            end
            if (sib_index != SIB_NO_INDEX) begin
                index_val = guest_reg[sib_index] << sib_scale;
            end
        end else if (!(f_mod == MOD_NO_DISP && f_rm == RM_DISP_ONLY)) begin
            base_val = guest_reg[f_rm];
        end
        disp_val = (dl_final == 3'd1) ? {{24{disp_next[7]}}, disp_next[7:0]} : disp_next;
        addr_val = (f_mod == MOD_REG) ? 32'd0 : (base_val + index_val + disp_val);
    end

    // Result record
    always_comb begin
        result = '0;
        if (bad_opcode) begin
            result.status       = STATUS_BAD_OPCODE;
            result.instr_length = 4'd1;
        end else begin
            result.status       = STATUS_OK;
            result.mem_address  = addr_val;
            result.instr_length = count_next;
            case (opcode_next)
                OPC_MOV_RM_R: begin
                    result.data_value = guest_reg[f_reg];
                    if (f_mod != MOD_REG) result.writes_memory = 1'b1;
                    else                  result.dest_reg      = f_rm;
                end
                OPC_MOV_R_RM: begin
                    result.dest_reg = f_reg;
                    if (f_mod != MOD_REG) result.reads_memory = 1'b1;
                    else                  result.data_value   = guest_reg[f_rm];
                end
                default: begin
                    result.data_value = imm_next;
                    if (f_mod != MOD_REG) result.writes_memory = 1'b1;
                    else                  result.dest_reg      = f_rm;
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg  <= PH_OPCODE;
            opcode_reg <= '0;
            modrm_reg  <= '0;
            sib_reg    <= '0;
            disp_reg   <= '0;
            imm_reg    <= '0;
            count_reg  <= '0;
            for (int i = 0; i < REG_COUNT; i++) begin
                guest_reg[i] <= '0;
            end
        end else begin
            if (item_fire && req_type == REQ_REG_WRITE) begin
                guest_reg[reg_index] <= reg_value;
            end
            if (emit) begin
                // drop the finished instruction, wait for the next opcode
                phase_reg  <= PH_OPCODE;
                opcode_reg <= '0;
                modrm_reg  <= '0;
                sib_reg    <= '0;
                disp_reg   <= '0;
                imm_reg    <= '0;
                count_reg  <= '0;
            end else begin
                phase_reg  <= phase_next;
                opcode_reg <= opcode_next;
                modrm_reg  <= modrm_next;
                sib_reg    <= sib_next;
                disp_reg   <= disp_next;
                imm_reg    <= imm_next;
                count_reg  <= count_next;
            end
        end
    end

endmodule
`default_nettype wire

// File: src/x86ea_pkg_dummy_guard.sv
`default_nettype none
// ----------------------------------------------------------------------------
// x86ea_outbuf: two-entry result buffer (output register plus skid register)
// Decouples the result channel from the input channel so that a single stalled
// result in the output register never blocks the transaction that follows it.
// ----------------------------------------------------------------------------
module x86ea_outbuf (
    input  wire logic                    aclk,
    input  wire logic                    aresetn,
    input  wire logic                    push,
    input  wire x86ea_pkg::ea_result_t   push_data,
    output logic                         full,
    output logic                         out_valid,
    input  wire logic                    out_ready,
    output x86ea_pkg::ea_result_t        out_data
);
    import x86ea_pkg::*;

    logic       out_valid_reg;
    logic       skid_valid_reg;
    ea_result_t out_reg;
    ea_result_t skid_reg;

    assign full      = skid_valid_reg;
    assign out_valid = out_valid_reg;
    assign out_data  = out_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end else if (!out_valid_reg || out_ready) begin
            // output slot frees up: refill from skid first, then from the parser
            if (skid_valid_reg) begin
                out_valid_reg  <= 1'b1;
                skid_valid_reg <= 1'b0;
            end else begin
                out_valid_reg <= push;
            end
        end else if (push) begin
            skid_valid_reg <= 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!out_valid_reg || out_ready) begin
            if (skid_valid_reg) out_reg <= skid_reg;
            else if (push)      out_reg <= push_data;
        end else if (push) begin
            skid_reg <= push_data;
        end
    end

endmodule
`default_nettype wire

// File: src/x86_mov_decode_effective_address_top.sv
`default_nettype none
// ----------------------------------------------------------------------------
// x86_mov_decode_effective_address_top: 32-bit MOV decoder with ModRM/SIB
// effective-address computation over eight guest registers.
// Results: a result enters the output buffer when the final instruction byte
//   (or an unsupported opcode) is accepted; results land in a two-entry buffer.
// Throughput: one transaction per cycle while the skid slot is free; the parse
//   update and address adder finish in the cycle a byte is accepted.
// Reset: aresetn low clears guest registers, parse state and both buffer slots.
// ----------------------------------------------------------------------------
module x86_mov_decode_effective_address_top (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    // request channel
    input  wire logic        s_valid,
    output logic             s_ready,
    input  wire logic        s_req_type,
    input  wire logic [2:0]  s_reg_index,
    input  wire logic [31:0] s_reg_value,
    input  wire logic [7:0]  s_code_byte,
    // result channel
    output logic             m_valid,
    input  wire logic        m_ready,
    output logic             m_status,
    output logic             m_writes_memory,
    output logic             m_reads_memory,
    output logic [2:0]       m_dest_reg,
    output logic [31:0]      m_mem_address,
    output logic [31:0]      m_data_value,
    output logic [3:0]       m_instr_length
);
    import x86ea_pkg::*;

    logic       s_fire;
    logic       emit;
    logic       buf_full;
    ea_result_t parse_result;
    ea_result_t out_result;

    // Accept whenever the skid slot is free: at most one result per
    // transaction, so an empty skid slot always has room for it.
    assign s_ready = !buf_full;
    assign s_fire  = s_valid && s_ready;

    // Parse state, guest registers and same-cycle result generation
    x86ea_parser u_parser (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .item_fire (s_fire),
        .req_type  (s_req_type),
        .reg_index (s_reg_index),
        .reg_value (s_reg_value),
        .code_byte (s_code_byte),
        .emit      (emit),
        .result    (parse_result)
    );

    // Hold results until the downstream side takes them
    x86ea_outbuf u_outbuf (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (emit),
        .push_data (parse_result),
        .full      (buf_full),
        .out_valid (m_valid),
        .out_ready (m_ready),
        .out_data  (out_result)
    );

    assign m_status        = out_result.status;
    assign m_writes_memory = out_result.writes_memory;
    assign m_reads_memory  = out_result.reads_memory;
    assign m_dest_reg      = out_result.dest_reg;
    assign m_mem_address   = out_result.mem_address;
    assign m_data_value    = out_result.data_value;
    assign m_instr_length  = out_result.instr_length;

    // A parked result in the skid slot implies the output slot is occupied
    a_skid_behind_out: assert property (@(posedge aclk) disable iff (!aresetn)
        buf_full |-> m_valid)
        else $error("skid slot holds a result while the output slot is empty");

    // An unsupported opcode is reported as a one-byte instruction with no access
    a_bad_opcode_shape: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_status == STATUS_BAD_OPCODE) |->
        (m_instr_length == 4'd1 && !m_writes_memory && !m_reads_memory))
        else $error("bad-opcode result carries decoded fields");

    // A decoded MOV never both reads and writes memory, and its length is legal
    a_decoded_shape: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_status == STATUS_OK) |->
        (!(m_writes_memory && m_reads_memory) && m_instr_length >= 4'd2
         && m_instr_length <= 4'd11))
        else $error("decoded result has inconsistent access flags or length");

    // An emitted result always lands in the buffer on the next cycle
    a_emit_lands: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_fire && emit) |=> m_valid)
        else $error("emitted result was lost");

endmodule
`default_nettype wire
